FILE: rtl/decimal_digit_display_scan_top_assert.svh
// Assertion macros for the decimal digit display scan block.
`ifndef DECIMAL_DIGIT_DISPLAY_SCAN_TOP_ASSERT_SVH
`define DECIMAL_DIGIT_DISPLAY_SCAN_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DDS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/ddscan_pkg.sv
// Package with widths, codes and sequencer states of the decimal digit display scan.
package ddscan_pkg;
	localparam int VALUE_W        = 16;
	localparam int COUNT_W        = 4;
	localparam int POS_W          = 3;
	localparam int CODE_W         = 4;
	localparam int BCD_DIGITS     = 5;
	localparam int BCD_W          = BCD_DIGITS * CODE_W;
	localparam int STEP_W         = 4;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 8;
	localparam int MAX_DIGITS_DEF = 8;

	localparam logic [CODE_W-1:0] BLANK_CODE = 4'd10;
	localparam logic [CODE_W-1:0] ADJ_LIMIT  = 4'd5;
	localparam logic [CODE_W-1:0] ADJ_ADD    = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;
endpackage

FILE: rtl/decimal_digit_display_scan_top.sv
// Decimal digit display scan: binary to BCD conversion and digit-by-digit result stream.
//
// Takes a 16-bit unsigned value and a digit count (0 acts as 1, counts above MAX_DIGITS
// saturate) and returns one transaction per used position, highest first, with leading
// zeros blanked (code 10) and tlast on position 0. A value passes through one load step,
// sixteen shift-add-3 iterations of the five per-digit BCD correction units, then one
// digit result per cycle while the sink keeps tready high. The block takes a new value
// only once the last digit of the previous one has been taken.
`include "decimal_digit_display_scan_top_assert.svh"

module decimal_digit_display_scan_top #(
	parameter int MAX_DIGITS = ddscan_pkg::MAX_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [15:0] value, [19:16] digit_count, [23:20] zero
	input  logic [ddscan_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [2:0] digit_position, [6:3] digit_code, [7] zero
	output logic [ddscan_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                             m_tlast
);

	ddscan_pkg::state_t state_q, state_next;

	logic [ddscan_pkg::VALUE_W-1:0]                           bin_q;
	logic [ddscan_pkg::BCD_DIGITS-1:0][ddscan_pkg::CODE_W-1:0] bcd_q;
	logic [ddscan_pkg::BCD_DIGITS-1:0][ddscan_pkg::CODE_W-1:0] bcd_adj;
	logic [ddscan_pkg::BCD_W-1:0]                             adj_flat;
	logic [ddscan_pkg::BCD_W-1:0]                             bcd_next;
	logic [ddscan_pkg::STEP_W-1:0]                            step_q;
	logic [ddscan_pkg::POS_W-1:0]                             pos_q;
	logic [ddscan_pkg::POS_W-1:0]                             pos_load;
	logic                                                     leading_q;
	logic [ddscan_pkg::COUNT_W-1:0]                           count_in;
	logic [ddscan_pkg::CODE_W-1:0]                            digit;
	logic [ddscan_pkg::CODE_W-1:0]                            code;
	logic                                                     blank;
	logic                                                     s_acc;
	logic                                                     m_acc;

	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign count_in = s_tdata[ddscan_pkg::VALUE_W +: ddscan_pkg::COUNT_W];

	always_comb begin
		priority if (count_in == '0) begin
			pos_load = '0;
		end else if (count_in > ddscan_pkg::COUNT_W'(MAX_DIGITS)) begin
			pos_load = ddscan_pkg::POS_W'(MAX_DIGITS - 1);
		end else begin
			pos_load = ddscan_pkg::POS_W'(count_in - 1'b1);
		end
	end

	always_comb begin
		for (int i = 0; i < ddscan_pkg::BCD_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= ddscan_pkg::ADJ_LIMIT) ?
				bcd_q[i] + ddscan_pkg::ADJ_ADD : bcd_q[i];
		end
		adj_flat = bcd_adj;
		bcd_next = {adj_flat[ddscan_pkg::BCD_W-2:0], bin_q[ddscan_pkg::VALUE_W-1]};
	end

	always_comb begin
		digit = (pos_q < ddscan_pkg::POS_W'(ddscan_pkg::BCD_DIGITS)) ? bcd_q[pos_q] : '0;
		blank = leading_q && (pos_q != '0) && (digit == '0);
		code  = blank ? ddscan_pkg::BLANK_CODE : digit;
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ddscan_pkg::ST_IDLE: begin
				if (s_tvalid) state_next = ddscan_pkg::ST_CONV;
			end
			ddscan_pkg::ST_CONV: begin
				if (step_q == '0) state_next = ddscan_pkg::ST_EMIT;
			end
			ddscan_pkg::ST_EMIT: begin
				if (m_tready && pos_q == '0) state_next = ddscan_pkg::ST_IDLE;
			end
			default: state_next = ddscan_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ddscan_pkg::ST_IDLE);
		m_tvalid = (state_q == ddscan_pkg::ST_EMIT);
		m_tdata  = {1'b0, code, pos_q};
		m_tlast  = (pos_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddscan_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			bin_q     <= s_tdata[ddscan_pkg::VALUE_W-1:0];
			bcd_q     <= '0;
			step_q    <= '1;
			pos_q     <= pos_load;
			leading_q <= 1'b1;
		end else if (state_q == ddscan_pkg::ST_CONV) begin
			bin_q  <= {bin_q[ddscan_pkg::VALUE_W-2:0], 1'b0};
			bcd_q  <= bcd_next;
			step_q <= step_q - 1'b1;
		end else if (m_acc) begin
			pos_q     <= pos_q - 1'b1;
			leading_q <= blank;
		end
	end

	`DDS_ASSERT_IMPL(a_ready_excl, clk, arst_n, s_tready, !m_tvalid)
	`DDS_ASSERT_NEXT(a_busy_after_acc, clk, arst_n, s_acc, !s_tready && !m_tvalid)
	`DDS_ASSERT_NEXT(a_idle_after_last, clk, arst_n, m_acc && m_tlast, s_tready)
	`DDS_ASSERT_IMPL(a_pos0_not_blank, clk, arst_n, m_tvalid && m_tlast, code != ddscan_pkg::BLANK_CODE)

endmodule
